@@ sv/bot_pkg.sv @@
package bot_pkg;

    // Table geometry
    localparam int TABLE_DEPTH = 32;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int KEEP        = TABLE_DEPTH / 2;
    localparam int SRC         = TABLE_DEPTH - KEEP;

    localparam int IDENT_W  = 16;
    localparam int OFFSET_W = 32;
    localparam int ENTRY_W  = IDENT_W + OFFSET_W;

    typedef enum logic {
        FUNC_ADD     = 1'b0,
        FUNC_RESOLVE = 1'b1
    } t_func;

    typedef enum logic [2:0] {
        ST_ADDED     = 3'd0,
        ST_DUPLICATE = 3'd1,
        ST_TRIMMED   = 3'd2,
        ST_RESOLVED  = 3'd3,
        ST_NOTFOUND  = 3'd4
    } t_status;

    typedef struct packed {
        t_func                 func;
        logic [IDENT_W-1:0]    boot_ident;
        logic [OFFSET_W-1:0]   time_value;
    } t_in;

    typedef struct packed {
        t_status               status;
        logic [OFFSET_W-1:0]   epoch;
    } t_out;

    typedef struct packed {
        logic [IDENT_W-1:0]    ident;
        logic [OFFSET_W-1:0]   offset;
    } t_entry;

    typedef struct packed {
        logic                  we;
        logic [IDX_W-1:0]      waddr;
        t_entry                wdata;
        logic [IDX_W-1:0]      raddr;
    } t_ram_req;

endpackage

@@ sv/bot_ram.sv @@
module bot_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ sv/bot_seq.sv @@
module bot_seq
    import bot_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_start,
    input  t_in      i_req,
    output logic     o_busy,
    output t_ram_req o_ram,
    input  t_entry   i_rdata,
    output logic     o_res_valid,
    output t_out     o_res,
    input  logic     i_res_take
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_TRIM,
        S_APPEND,
        S_EPOCH,
        S_DONE
    } t_state;

    t_state              r_state, n_state;
    logic [CNT_W-1:0]    r_count, n_count;
    logic [CNT_W-1:0]    r_idx,   n_idx;
    logic                r_pend,  n_pend;
    logic [IDX_W-1:0]    r_pidx,  n_pidx;
    logic                r_trim,  n_trim;
    t_in                 r_req,   n_req;
    logic [OFFSET_W-1:0] r_offset, n_offset;
    t_out                r_res,   n_res;
    logic                w_hit;

    // single shared comparator: stored ident vs. requested ident
    assign w_hit = (i_rdata.ident == r_req.boot_ident);

    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_idx    = r_idx;
        n_pend   = r_pend;
        n_pidx   = r_pidx;
        n_trim   = r_trim;
        n_req    = r_req;
        n_offset = r_offset;
        n_res    = r_res;
        o_ram    = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_req   = i_req;
                    n_idx   = '0;
                    n_pend  = 1'b0;
                    n_trim  = 1'b0;
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (r_pend && w_hit) begin
                    n_offset = i_rdata.offset;
                    n_pend   = 1'b0;
                    if (r_req.func == FUNC_RESOLVE) begin
                        n_state = S_EPOCH;
                    end else begin
                        n_res.status = ST_DUPLICATE;
                        n_res.epoch  = '0;
                        n_state      = S_DONE;
                    end
                end else if (r_idx < r_count) begin
                    o_ram.raddr = r_idx[IDX_W-1:0];
                    n_idx       = r_idx + 1'b1;
                    n_pend      = 1'b1;
                end else if (r_pend) begin
                    n_pend = 1'b0;
                end else begin
                    case (r_req.func)
                        FUNC_RESOLVE: begin
                            n_res.status = ST_NOTFOUND;
                            n_res.epoch  = '0;
                            n_state      = S_DONE;
                        end
                        FUNC_ADD: begin
                            if (r_count == CNT_W'(TABLE_DEPTH)) begin
                                n_trim  = 1'b1;
                                n_idx   = '0;
                                n_state = S_TRIM;
                            end else begin
                                n_state = S_APPEND;
                            end
                        end
                        default: n_state = S_IDLE;
                    endcase
                end
            end
            S_TRIM: begin
                // read newest half, write each entry back at the front in the following cycle
                if (r_pend) begin
                    o_ram.we    = 1'b1;
                    o_ram.waddr = r_pidx;
                    o_ram.wdata = i_rdata;
                end
                if (r_idx < CNT_W'(KEEP)) begin
                    o_ram.raddr = IDX_W'(SRC) + r_idx[IDX_W-1:0];
                    n_pidx      = r_idx[IDX_W-1:0];
                    n_idx       = r_idx + 1'b1;
                    n_pend      = 1'b1;
                end else if (r_pend) begin
                    n_pend = 1'b0;
                end else begin
                    n_count = CNT_W'(KEEP);
                    n_state = S_APPEND;
                end
            end
            S_APPEND: begin
                o_ram.we           = 1'b1;
                o_ram.waddr        = r_count[IDX_W-1:0];
                o_ram.wdata.ident  = r_req.boot_ident;
                o_ram.wdata.offset = r_req.time_value;
                n_count            = r_count + 1'b1;
                n_res.status       = r_trim ? ST_TRIMMED : ST_ADDED;
                n_res.epoch        = '0;
                n_state            = S_DONE;
            end
            S_EPOCH: begin
                n_res.status = ST_RESOLVED;
                n_res.epoch  = r_offset + r_req.time_value;
                n_state      = S_DONE;
            end
            S_DONE: begin
                if (i_res_take) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_idx   <= '0;
            r_pend  <= 1'b0;
            r_trim  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_idx   <= n_idx;
            r_pend  <= n_pend;
            r_trim  <= n_trim;
        end
        r_pidx   <= n_pidx;
        r_req    <= n_req;
        r_offset <= n_offset;
        r_res    <= n_res;
    end

    assign o_busy      = (r_state != S_IDLE);
    assign o_res_valid = (r_state == S_DONE);
    assign o_res       = r_res;

endmodule

@@ sv/boot_offset_table.sv @@
// Operation: a request scans the N-entry table (N <= 32), stopping at a hit; a hit
//   on a resolve adds the request time to the stored offset, and an add that misses
//   appends, first trimming a full table to its newest half.
// Throughput: one request at a time; the next transfer is taken once the result has
//   moved into the output register. The pace is set by the single ident comparator
//   reading one table entry per cycle from the registered-read RAM port.
// Reset (synchronous, active low) empties the table and drops any pending result.
module boot_offset_table
    import bot_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    // request channel
    input  logic i_in_valid,
    output logic o_in_stall,
    input  t_in  i_in,
    // result channel
    output logic o_out_valid,
    input  logic i_out_stall,
    output t_out o_out
);

    t_ram_req w_ram;
    t_entry   w_rdata;
    logic     w_busy;
    logic     w_in_xfer;
    logic     w_res_valid;
    t_out     w_res;
    logic     w_take;
    logic     r_out_vld;
    t_out     r_out;

    // Request transfer: block is idle and upstream offers an item.
    assign o_in_stall = w_busy;
    assign w_in_xfer  = i_in_valid && !w_busy;

    // Identifier/offset table, one entry per RAM word.
    bot_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram.we),
        .i_waddr (w_ram.waddr),
        .i_wdata (w_ram.wdata),
        .i_raddr (w_ram.raddr),
        .o_rdata (w_rdata)
    );

    // Sequencer: scan, trim, append and epoch add around one comparator.
    bot_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (w_in_xfer),
        .i_req       (i_in),
        .o_busy      (w_busy),
        .o_ram       (w_ram),
        .i_rdata     (w_rdata),
        .o_res_valid (w_res_valid),
        .o_res       (w_res),
        .i_res_take  (w_take)
    );

    // Output register: loads when empty or when its current result is transferred.
    assign w_take = w_res_valid && (!r_out_vld || !i_out_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_take) begin
            r_out_vld <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_out <= w_res;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out       = r_out;

    // A request transfer always makes the block busy on the next cycle.
    a_busy_after_xfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_xfer |=> o_in_stall)
        else $error("block not busy after request transfer");

    // Only a resolved lookup carries a nonzero epoch.
    a_epoch_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out.status != ST_RESOLVED)) |-> (o_out.epoch == '0))
        else $error("nonzero epoch on unresolved result");

    // A result handed over by the sequencer shows up at the output next cycle.
    a_take_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_take |=> (o_out_valid && (o_out == $past(w_res))))
        else $error("result lost between sequencer and output register");

endmodule

@@ tb/boot_offset_table_check.sv @@
`timescale 1ns / 1ps

module boot_offset_table_check
    import bot_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    input  logic i_in_stall,
    input  t_in  i_in,
    input  logic i_out_valid,
    input  logic i_out_stall,
    input  t_out i_out,
    output int   o_fail_cnt,
    output int   o_results_due
);

    // Shadow copy of the table, kept in boot order.
    logic [IDENT_W-1:0]  ident_tab  [TABLE_DEPTH];
    logic [OFFSET_W-1:0] offset_tab [TABLE_DEPTH];
    int                  fill_level = 0;

    t_out expected_results[$];
    t_out want;
    int   fails = 0;

    // Applies one request to the shadow table and returns the result it must give.
    function automatic t_out apply_request(t_in req);
        t_out res;
        int   hit;
        int   k;
        res.status = ST_NOTFOUND;
        res.epoch  = '0;
        hit        = -1;
        for (k = 0; k < fill_level; k++) begin
            if (hit < 0 && ident_tab[k] == req.boot_ident) begin
                hit = k;
            end
        end
        if (req.func == FUNC_RESOLVE) begin
            if (hit >= 0) begin
                res.status = ST_RESOLVED;
                res.epoch  = offset_tab[hit] + req.time_value;
            end
        end else if (hit >= 0) begin
            res.status = ST_DUPLICATE;   // first write wins
        end else begin
            res.status = ST_ADDED;
            if (fill_level == TABLE_DEPTH) begin
                // full: newest half slides to the front, older half dropped
                for (k = 0; k < KEEP; k++) begin
                    ident_tab[k]  = ident_tab[SRC + k];
                    offset_tab[k] = offset_tab[SRC + k];
                end
                fill_level = KEEP;
                res.status = ST_TRIMMED;
            end
            ident_tab[fill_level]  = req.boot_ident;
            offset_tab[fill_level] = req.time_value;
            fill_level++;
        end
        return res;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            expected_results.delete();
            fill_level = 0;
            o_results_due <= 0;
        end else begin
            // a result cannot come out in the cycle its request is taken, so compare before queuing new work
            if (i_out_valid && !i_out_stall) begin
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result, status %0d epoch %h",
                             $time, i_out.status, i_out.epoch);
                    fails++;
                end else begin
                    want = expected_results.pop_front();
                    if (i_out.status !== want.status) begin
                        $display("%0t: status mismatch, expected %0d, actual %0d",
                                 $time, want.status, i_out.status);
                        fails++;
                    end
                    if (i_out.epoch !== want.epoch) begin
                        $display("%0t: epoch mismatch, expected %h, actual %h",
                                 $time, want.epoch, i_out.epoch);
                        fails++;
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                expected_results.push_back(apply_request(i_in));
            end
            o_results_due <= expected_results.size();
        end
        o_fail_cnt <= fails;
    end

endmodule

@@ tb/boot_offset_table_test.sv @@
`timescale 1ns / 1ps

module boot_offset_table_test;
    import bot_pkg::*;

    localparam int RANDOM_REQS    = 1900;
    localparam int STALL_PCT      = 20;     // idle odds per cycle, both sides
    localparam int QUIET_FROM     = 500;    // random request index where idling stops
    localparam int QUIET_TO       = 900;    // ... and where it resumes with a hold-off
    localparam int HOLD_CYCLES    = 400;    // long receiver hold-off
    localparam int DRAIN_CYCLES   = 80;     // linger after the last expected result
    localparam int WATCHDOG_LIMIT = 3000;   // hold-off + trim latency, several times over

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic i_in_valid;
    logic o_in_stall;
    t_in  i_in;
    logic o_out_valid;
    logic i_out_stall;
    t_out o_out;

    int fail_cnt;
    int results_due;

    // Shared knobs: each has exactly one writer; quiet and hold_asked are set by stimulus, read by the sink.
    bit quiet      = 1'b0;
    int hold_asked = 0;
    int hold_given = 0;    // written by the sink only

    int idle_cycles = 0;

    // Latest 48 idents handed out; the random part draws hits and duplicates from here.
    logic [IDENT_W-1:0] seen_ids[$];

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    boot_offset_table dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out)
    );

    // Watches both channels, predicts every result and counts mismatches.
    boot_offset_table_check u_check (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .i_in_stall    (o_in_stall),
        .i_in          (i_in),
        .i_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .i_out         (o_out),
        .o_fail_cnt    (fail_cnt),
        .o_results_due (results_due)
    );

    function automatic t_in make_req(t_func f, logic [IDENT_W-1:0] id,
                                     logic [OFFSET_W-1:0] tv);
        t_in r;
        r.func       = f;
        r.boot_ident = id;
        r.time_value = tv;
        return r;
    endfunction

    // Offers one request and returns at the falling edge after its transfer.
    // Valid only drops for an idle gap, so it is never lowered and raised in one step.
    task automatic push_request(input t_in req);
        while (!quiet && $urandom_range(99) < STALL_PCT) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in       <= req;
        i_in_valid <= 1'b1;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Mostly well-formed traffic: fresh adds that fill and trim the table,
    // resolves of idents known to have been added (some since trimmed away),
    // re-adds that hit the duplicate path, and some blind lookups as noise.
    task automatic random_request();
        logic [IDENT_W-1:0]  id;
        logic [OFFSET_W-1:0] tv;
        int                  pick;
        pick = $urandom_range(99);
        tv   = $urandom;
        if ($urandom_range(9) == 0) begin
            tv = $urandom_range(1) ? {OFFSET_W{1'b1}} : '0;   // wrap edges
        end
        if (seen_ids.size() == 0 || pick < 35) begin
            id = IDENT_W'($urandom);
            seen_ids.push_back(id);
            if (seen_ids.size() > 48) void'(seen_ids.pop_front());
            push_request(make_req(FUNC_ADD, id, tv));
        end else if (pick < 45) begin
            id = seen_ids[$urandom_range(seen_ids.size() - 1)];
            push_request(make_req(FUNC_ADD, id, tv));
        end else if (pick < 85) begin
            id = seen_ids[$urandom_range(seen_ids.size() - 1)];
            push_request(make_req(FUNC_RESOLVE, id, tv));
        end else begin
            id = IDENT_W'($urandom);
            push_request(make_req(FUNC_RESOLVE, id, tv));
        end
    endtask

    // Result side: random stall, none in the quiet stretch, one long hold-off
    // on request. The hold-off is counted here so the sender keeps offering.
    initial begin : result_sink
        i_out_stall <= 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_asked != hold_given) begin
                hold_given++;
                i_out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge i_clk);
            end
            i_out_stall <= !quiet && ($urandom_range(99) < STALL_PCT);
        end
    end

    // Watchdog: any transfer on either channel restarts the count.
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles == WATCHDOG_LIMIT) begin
            $display("boot_offset_table_test NOT OK");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin : stimulus
        int n;
        i_rst_n    <= 1'b0;
        i_in_valid <= 1'b0;
        i_in       <= '0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // lookup on an empty table
        push_request(make_req(FUNC_RESOLVE, 16'h0000, 32'h0000_0000));
        // field extremes
        push_request(make_req(FUNC_ADD,     16'h0000, 32'h0000_0000));
        push_request(make_req(FUNC_ADD,     16'hFFFF, 32'hFFFF_FFFF));
        push_request(make_req(FUNC_RESOLVE, 16'hFFFF, 32'h0000_0001));   // wraps to zero
        push_request(make_req(FUNC_RESOLVE, 16'h0000, 32'hFFFF_FFFF));
        // duplicate add leaves the first offset in place
        push_request(make_req(FUNC_ADD,     16'hFFFF, 32'h1234_5678));
        push_request(make_req(FUNC_RESOLVE, 16'hFFFF, 32'h0000_0000));
        // miss on a populated table, then a hit on the same ident
        push_request(make_req(FUNC_RESOLVE, 16'h1234, 32'h0000_0005));
        push_request(make_req(FUNC_ADD,     16'h1234, 32'h8000_0000));
        push_request(make_req(FUNC_RESOLVE, 16'h1234, 32'h8000_0000));
        // alternating bit patterns
        push_request(make_req(FUNC_ADD,     16'hAAAA, 32'h5555_5555));
        push_request(make_req(FUNC_RESOLVE, 16'h5555, 32'hAAAA_AAAA));
        push_request(make_req(FUNC_RESOLVE, 16'hAAAA, 32'hAAAA_AAAA));

        // random traffic; trims come from the fresh adds filling the table
        for (n = 0; n < RANDOM_REQS; n++) begin
            if (n == QUIET_FROM) quiet = 1'b1;
            if (n == QUIET_TO) begin
                quiet = 1'b0;
                hold_asked++;
            end
            random_request();
        end
        i_in_valid <= 1'b0;

        // drain, then linger to catch stray results
        while (results_due != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (fail_cnt == 0) begin
            $display("boot_offset_table_test OK");
        end else begin
            $display("boot_offset_table_test NOT OK");
        end
        $finish;
    end

endmodule
